@@ src/satq_pkg.sv @@
// ----------------------------------------------------------------------------
// satq_pkg
// Shared constants and types for the sorted alarm timer queue.
// ----------------------------------------------------------------------------
package satq_pkg;

  // fixed field widths
  localparam int TICK_W   = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  // most alarms released by one tick
  localparam int MAX_OUT  = 16;
  localparam int FIRE_W   = $clog2(MAX_OUT + 1);

  // input operation codes
  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SET   = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_IDLE  = 2'd2
  } kind_e;

  // set acknowledge status
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_RESP = 2'd1,
    FSM_INS  = 2'd2,
    FSM_TICK = 2'd3
  } state_e;

endpackage

@@ src/satq_in_if.sv @@
// ----------------------------------------------------------------------------
// satq_in_if
// Request channel: set alarm or timer tick, valid/ready handshake.
// ----------------------------------------------------------------------------
interface satq_in_if #(
  parameter int ID_BITS = 8
);
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [ID_BITS-1:0]          alarm_id;
  logic [satq_pkg::TICK_W-1:0] deadline;

  modport source (output valid, output op, output alarm_id, output deadline, input ready);
  modport sink   (input valid, input op, input alarm_id, input deadline, output ready);
endinterface

@@ src/satq_out_if.sv @@
// ----------------------------------------------------------------------------
// satq_out_if
// Result channel: acknowledges, fired alarms and idle ticks.
// ----------------------------------------------------------------------------
interface satq_out_if #(
  parameter int ID_BITS = 8
);
  logic                          valid;
  logic                          ready;
  logic [satq_pkg::KIND_W-1:0]   kind;
  logic [satq_pkg::STATUS_W-1:0] status;
  logic [ID_BITS-1:0]            fired_id;
  logic [satq_pkg::TICK_W-1:0]   tick_now;
  logic                          last;

  modport source (output valid, output kind, output status, output fired_id,
                  output tick_now, output last, input ready);
  modport sink   (input valid, input kind, input status, input fired_id,
                  input tick_now, input last, output ready);
endinterface

@@ src/satq_store.sv @@
// ----------------------------------------------------------------------------
// satq_store
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module satq_store #(
  parameter int  DEPTH = 16,
  parameter int  WIDTH = 40,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/sorted_alarm_timer_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue
// Tick counter with a deadline-sorted queue of pending alarms.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries set (op 0: alarm_id, deadline) and tick (op 1) transactions.
//   out_o returns one acknowledge per set and, per tick, one transaction per
//   fired alarm in deadline order (at most 16) or one idle result; last marks
//   the final result of each request. cfg_we_i loads cfg_wdata_i into the
//   counter and empties the queue; write it only while the block is idle.
// Sequencing:
//   set: a rejected set (zero deadline or full queue) goes straight to the
//        acknowledge; otherwise the walk starts at the tail and moves each
//        queued entry with a later deadline up one slot, one entry per cycle
//        through the one read port and one write port of the entry memory.
//   tick: advances the counter, then fires expired heads; one memory read per queue head.
//   One request is in flight at a time; in_i.ready is high only when idle.
// The queue is a circular buffer in the entry memory, tracked by a head
// pointer and a fill count, so reset needs no clearing pass: after reset the
// counter is 0 and the queue is empty. A stalled out_o holds the output
// register and the sequencer waits; no result is dropped.
// ----------------------------------------------------------------------------
module sorted_alarm_timer_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [satq_pkg::TICK_W-1:0] cfg_wdata_i,
  satq_in_if.sink                     in_i,
  satq_out_if.source                  out_o
);
  import satq_pkg::*;

  localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = IDX_W + 1;
  localparam int ENTRY_W = TICK_W + ID_BITS;
  localparam logic [CNT_W-1:0]  DepthCnt = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0]  DepthSum = SUM_W'(QUEUE_DEPTH);
  localparam logic [FIRE_W-1:0] MaxFire  = FIRE_W'(MAX_OUT);

  // queue position to memory address, wrapping at the depth
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [IDX_W-1:0] ofs);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, head} + {1'b0, ofs};
    if (sum >= DepthSum) begin
      sum = sum - DepthSum;
    end
    return sum[IDX_W-1:0];
  endfunction

  state_e              state_q, state_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [FIRE_W-1:0]   fire_q, fire_d;
  logic [ID_BITS-1:0]  pend_id_q, pend_id_d;
  logic [TICK_W-1:0]   dl_q, dl_d;
  logic [ID_BITS-1:0]  id_q, id_d;
  status_e             status_q, status_d;

  logic                out_valid_q;
  kind_e               out_kind_q, out_kind_d;
  status_e             out_status_q, out_status_d;
  logic [ID_BITS-1:0]  out_id_q, out_id_d;
  logic [TICK_W-1:0]   out_tick_q;
  logic                out_last_q, out_last_d;
  logic                load_out;
  logic                out_free;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_raddr;
  logic [ENTRY_W-1:0]  rd_data;
  logic [TICK_W-1:0]   rd_dl;
  logic [ID_BITS-1:0]  rd_id;
  logic                due;

  // entry memory: deadline above id
  satq_store #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_data)
  );

  assign rd_dl = rd_data[ENTRY_W-1:ID_BITS];
  assign rd_id = rd_data[ID_BITS-1:0];

  // handshake side signals
  assign in_i.ready = (state_q == FSM_IDLE) && !cfg_we_i;
  assign out_free   = !out_valid_q || out_o.ready;

  // head entry has expired and may still fire on this tick
  assign due = (count_q != '0) && (fire_q < MaxFire) && (rd_dl <= tick_q);

  // sequencer: next state, memory access and result loading
  always_comb begin
    state_d      = state_q;
    tick_d       = tick_q;
    head_d       = head_q;
    count_d      = count_q;
    idx_d        = idx_q;
    fire_d       = fire_q;
    pend_id_d    = pend_id_q;
    dl_d         = dl_q;
    id_d         = id_q;
    status_d     = status_q;
    mem_we       = 1'b0;
    mem_waddr    = phys(head_q, idx_q);
    mem_wdata    = {dl_q, id_q};
    mem_re       = 1'b0;
    mem_raddr    = phys(head_q, idx_q - IDX_W'(1));
    load_out     = 1'b0;
    out_kind_d   = KIND_SET;
    out_status_d = ST_OK;
    out_id_d     = '0;
    out_last_d   = 1'b1;

    unique case (state_q)
      FSM_IDLE: begin
        if (cfg_we_i) begin
          tick_d  = cfg_wdata_i;
          head_d  = '0;
          count_d = '0;
        end else if (in_i.valid) begin
          if (in_i.op == OP_SET) begin
            dl_d  = in_i.deadline;
            id_d  = in_i.alarm_id;
            idx_d = count_q[IDX_W-1:0];
            if (in_i.deadline == '0) begin
              status_d = ST_ZERO;
              state_d  = FSM_RESP;
            end else if (count_q == DepthCnt) begin
              status_d = ST_FULL;
              state_d  = FSM_RESP;
            end else begin
              // start the walk at the tail
              status_d  = ST_OK;
              state_d   = FSM_INS;
              mem_re    = (count_q != '0);
              mem_raddr = phys(head_q, count_q[IDX_W-1:0] - IDX_W'(1));
            end
          end else begin
            tick_d    = tick_q + TICK_W'(1);
            fire_d    = '0;
            state_d   = FSM_TICK;
            mem_re    = (count_q != '0);
            mem_raddr = head_q;
          end
        end
      end

      FSM_RESP: begin
        if (out_free) begin
          load_out     = 1'b1;
          out_kind_d   = KIND_SET;
          out_status_d = status_q;
          out_last_d   = 1'b1;
          state_d      = FSM_IDLE;
        end
      end

      FSM_INS: begin
        mem_we = 1'b1;
        if ((idx_q == '0) || (rd_dl <= dl_q)) begin
          // slot found: place the new alarm here
          mem_wdata = {dl_q, id_q};
          count_d   = count_q + CNT_W'(1);
          state_d   = FSM_RESP;
        end else begin
          // later deadline moves up one slot, read the next one down
          mem_wdata = rd_data;
          idx_d     = idx_q - IDX_W'(1);
          if (idx_q != IDX_W'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = phys(head_q, idx_q - IDX_W'(2));
          end
        end
      end

      FSM_TICK: begin
        if (out_free) begin
          // previous fired alarm goes out once its successor is known
          if (fire_q != '0) begin
            load_out   = 1'b1;
            out_kind_d = KIND_FIRED;
            out_id_d   = pend_id_q;
            out_last_d = !due;
          end
          if (due) begin
            pend_id_d = rd_id;
            head_d    = phys(head_q, IDX_W'(1));
            count_d   = count_q - CNT_W'(1);
            fire_d    = fire_q + FIRE_W'(1);
            mem_re    = 1'b1;
            mem_raddr = phys(head_q, IDX_W'(1));
          end else begin
            if (fire_q == '0) begin
              load_out   = 1'b1;
              out_kind_d = KIND_IDLE;
              out_last_d = 1'b1;
            end
            state_d = FSM_IDLE;
          end
        end
      end

      default: state_d = FSM_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      tick_q      <= '0;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      fire_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      fire_q  <= fire_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    dl_q      <= dl_d;
    id_q      <= id_d;
    status_q  <= status_d;
    if (load_out) begin
      out_kind_q   <= out_kind_d;
      out_status_q <= out_status_d;
      out_id_q     <= out_id_d;
      out_tick_q   <= tick_q;
      out_last_q   <= out_last_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.kind     = out_kind_q;
  assign out_o.status   = out_status_q;
  assign out_o.fired_id = out_id_q;
  assign out_o.tick_now = out_tick_q;
  assign out_o.last     = out_last_q;

  // fill count never passes the depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("queue fill count beyond depth");

  // an accepted tick advances the counter by one
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.op == OP_TICK))
      |=> (tick_q == $past(tick_q) + TICK_W'(1)))
    else $error("tick counter did not advance");

  // only the insert walk writes the entry memory
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == FSM_INS))
    else $error("entry memory written outside insert");

  // no more alarms fire on one tick than allowed
  a_fire_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_q <= MaxFire)
    else $error("fired count beyond limit");

endmodule
